[rtl/vpci_pkg.sv]
// Shared types, codes and arithmetic helpers of the vector path command interpreter.
`default_nettype none
package vpci_pkg;

    localparam logic [3:0] CMD_MOVE   = 4'd0;
    localparam logic [3:0] CMD_LINE   = 4'd1;
    localparam logic [3:0] CMD_HORIZ  = 4'd2;
    localparam logic [3:0] CMD_VERT   = 4'd3;
    localparam logic [3:0] CMD_CUBIC  = 4'd4;
    localparam logic [3:0] CMD_SCUBIC = 4'd5;
    localparam logic [3:0] CMD_QUAD   = 4'd6;
    localparam logic [3:0] CMD_SQUAD  = 4'd7;
    localparam logic [3:0] CMD_ARC    = 4'd8;
    localparam logic [3:0] CMD_CLOSE  = 4'd9;
    localparam logic [3:0] CMD_REPEAT = 4'd10;
    localparam logic [3:0] CMD_NONE   = 4'd15;

    localparam logic [2:0] SEG_MOVE  = 3'd0;
    localparam logic [2:0] SEG_LINE  = 3'd1;
    localparam logic [2:0] SEG_CUBIC = 3'd2;
    localparam logic [2:0] SEG_QUAD  = 3'd3;
    localparam logic [2:0] SEG_ARC   = 3'd4;
    localparam logic [2:0] SEG_CLOSE = 3'd5;
    localparam logic [2:0] SEG_ERROR = 3'd6;

    // round(pi / 180 * 2^32)
    localparam logic [27:0] DEG2RAD_Q32 = 28'd74961321;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam int IN_TDATA_W   = 200;
    localparam int IN_TUSER_W   = 5;
    localparam int OUT_TDATA_W  = 200;
    localparam int OUT_TUSER_W  = 3;

    typedef logic signed [31:0] coord_t;

    typedef struct packed {
        logic [3:0]         op;
        logic               err;
        logic               rel;
        logic               refl;
        coord_t             a;
        coord_t             b;
        coord_t             c;
        coord_t             d;
        coord_t             e;
        coord_t             f;
        logic signed [58:0] prod;
        logic               lg;
        logic               sw;
    } front_item_t;

    typedef struct packed {
        logic [3:0] op;
        logic       err;
        logic       rel;
        logic       refl;
        coord_t     a;
        coord_t     b;
        coord_t     c;
        coord_t     d;
        coord_t     e;
        coord_t     f;
        coord_t     rad;
        logic       lg;
        logic       sw;
    } queue_item_t;

    function automatic coord_t sat34(input logic signed [33:0] v);
        coord_t r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic coord_t add_sat(input coord_t x, input coord_t y);
        logic signed [33:0] s;
        s = {{2{x[31]}}, x} + {{2{y[31]}}, y};
        return sat34(s);
    endfunction

    function automatic coord_t reflect_sat(input coord_t about, input coord_t c);
        logic signed [33:0] s;
        s = {about[31], about, 1'b0} - {{2{c[31]}}, c};
        return sat34(s);
    endfunction

endpackage
`default_nettype wire

[rtl/vpci_front.sv]
// Front part: accepts requests, resolves repeats and errors, and starts the rotation multiply.
`default_nettype none
module vpci_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [vpci_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic [vpci_pkg::IN_TUSER_W-1:0] s_tuser,
    output logic                              q_push,
    output vpci_pkg::queue_item_t             q_item,
    input  wire logic                         q_full
);
    import vpci_pkg::*;

    logic        stage_valid_reg, stage_valid_next;
    front_item_t stage_reg;
    front_item_t stage_next;
    logic [3:0]  verb_kind_reg, verb_kind_next;
    logic        verb_rel_reg, verb_rel_next;
    logic        failed_reg, failed_next;
    logic        accept;
    logic [3:0]  cmd;
    logic        rel;
    logic        fail_now;
    logic signed [58:0] rounded;

    assign s_tready = !stage_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = stage_valid_reg && !q_full;

    always_comb begin
        cmd      = s_tuser[3:0];
        rel      = s_tuser[4];
        fail_now = failed_reg;
        if (!failed_reg && cmd == CMD_REPEAT) begin
            if (verb_kind_reg == CMD_NONE) begin
                fail_now = 1'b1;
            end else begin
                cmd = (verb_kind_reg == CMD_MOVE) ? CMD_LINE : verb_kind_reg;
                rel = verb_rel_reg;
            end
        end
        if (!fail_now && cmd > CMD_CLOSE) begin
            fail_now = 1'b1;
        end

        stage_next.op   = cmd;
        stage_next.err  = fail_now;
        stage_next.rel  = rel;
        stage_next.refl = (cmd == CMD_SCUBIC && verb_kind_reg inside {CMD_CUBIC, CMD_SCUBIC})
                       || (cmd == CMD_SQUAD && verb_kind_reg inside {CMD_QUAD, CMD_SQUAD});
        stage_next.a    = s_tdata[31:0];
        stage_next.b    = s_tdata[63:32];
        stage_next.c    = s_tdata[95:64];
        stage_next.d    = s_tdata[127:96];
        stage_next.e    = s_tdata[159:128];
        stage_next.f    = s_tdata[191:160];
        stage_next.prod = $signed({{27{s_tdata[95]}}, s_tdata[95:64]})
                        * $signed({31'd0, DEG2RAD_Q32});
        stage_next.lg   = s_tdata[192];
        stage_next.sw   = s_tdata[193];

        failed_next      = failed_reg;
        verb_kind_next   = verb_kind_reg;
        verb_rel_next    = verb_rel_reg;
        stage_valid_next = stage_valid_reg && q_full;
        if (accept) begin
            stage_valid_next = 1'b1;
            failed_next      = fail_now;
            if (!fail_now) begin
                verb_kind_next = cmd;
                verb_rel_next  = rel;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            failed_reg      <= 1'b0;
            verb_kind_reg   <= CMD_NONE;
            verb_rel_reg    <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            failed_reg      <= failed_next;
            verb_kind_reg   <= verb_kind_next;
            verb_rel_reg    <= verb_rel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    // Round half up, then keep the integer part of the Q32 product.
    assign rounded = stage_reg.prod + 59'sh0_8000_0000;

    always_comb begin
        q_item.op   = stage_reg.op;
        q_item.err  = stage_reg.err;
        q_item.rel  = stage_reg.rel;
        q_item.refl = stage_reg.refl;
        q_item.a    = stage_reg.a;
        q_item.b    = stage_reg.b;
        q_item.c    = stage_reg.c;
        q_item.d    = stage_reg.d;
        q_item.e    = stage_reg.e;
        q_item.f    = stage_reg.f;
        q_item.rad  = {{5{rounded[58]}}, rounded[58:32]};
        q_item.lg   = stage_reg.lg;
        q_item.sw   = stage_reg.sw;
    end

`ifndef SYNTHESIS
    a_failed_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        failed_reg |=> failed_reg)
        else $error("error state was left without reset");
    a_failed_item_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && failed_reg) |=> stage_reg.err)
        else $error("request after failure was not marked as an error");
`endif
endmodule
`default_nettype wire

[rtl/vpci_queue.sv]
// Short queue of classified requests between the front and back parts.
`default_nettype none
module vpci_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire vpci_pkg::queue_item_t push_item,
    output logic                       full,
    input  wire logic                  pop,
    output vpci_pkg::queue_item_t      pop_item,
    output logic                       not_empty
);
    import vpci_pkg::*;

    queue_item_t             slots_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]       count_reg, count_next;

    assign full      = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && !not_empty))
        else $error("queue read while empty");
`endif
endmodule
`default_nettype wire

[rtl/vpci_back.sv]
// Back part: tracks the pen and control points and builds each absolute segment.
`default_nettype none
module vpci_back (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  wire vpci_pkg::queue_item_t       q_item,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [vpci_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [vpci_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import vpci_pkg::*;

    coord_t pen_x_reg, pen_x_next, pen_y_reg, pen_y_next;
    coord_t start_x_reg, start_x_next, start_y_reg, start_y_next;
    coord_t ctrl_x_reg, ctrl_x_next, ctrl_y_reg, ctrl_y_next;
    logic   out_valid_reg, out_valid_next;
    logic [2:0] kind_reg, kind_next;
    coord_t first_x_reg, first_x_next, first_y_reg, first_y_next;
    coord_t second_x_reg, second_x_next, second_y_reg, second_y_next;
    coord_t end_x_reg, end_y_reg;
    logic   large_reg, large_next, sweep_reg, sweep_next;
    coord_t fx, fy, refl_x, refl_y;
    coord_t sum_ax, sum_by, sum_cx, sum_dy, sum_ex, sum_fy, sum_ay;

    assign q_pop    = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, sweep_reg, large_reg, end_y_reg, end_x_reg,
                       second_y_reg, second_x_reg, first_y_reg, first_x_reg};

    always_comb begin
        fx     = q_item.rel ? pen_x_reg : '0;
        fy     = q_item.rel ? pen_y_reg : '0;
        refl_x = q_item.refl ? reflect_sat(pen_x_reg, ctrl_x_reg) : pen_x_reg;
        refl_y = q_item.refl ? reflect_sat(pen_y_reg, ctrl_y_reg) : pen_y_reg;
        sum_ax = add_sat(fx, q_item.a);
        sum_by = add_sat(fy, q_item.b);
        sum_cx = add_sat(fx, q_item.c);
        sum_dy = add_sat(fy, q_item.d);
        sum_ex = add_sat(fx, q_item.e);
        sum_fy = add_sat(fy, q_item.f);
        sum_ay = add_sat(fy, q_item.a);
    end

    always_comb begin
        pen_x_next    = pen_x_reg;
        pen_y_next    = pen_y_reg;
        start_x_next  = start_x_reg;
        start_y_next  = start_y_reg;
        ctrl_x_next   = ctrl_x_reg;
        ctrl_y_next   = ctrl_y_reg;
        kind_next     = SEG_ERROR;
        first_x_next  = '0;
        first_y_next  = '0;
        second_x_next = '0;
        second_y_next = '0;
        large_next    = 1'b0;
        sweep_next    = 1'b0;
        if (!q_item.err) begin
            case (q_item.op)
                CMD_MOVE: begin
                    kind_next    = SEG_MOVE;
                    pen_x_next   = sum_ax;
                    pen_y_next   = sum_by;
                    start_x_next = sum_ax;
                    start_y_next = sum_by;
                end
                CMD_LINE: begin
                    kind_next  = SEG_LINE;
                    pen_x_next = sum_ax;
                    pen_y_next = sum_by;
                end
                CMD_HORIZ: begin
                    kind_next  = SEG_LINE;
                    pen_x_next = sum_ax;
                end
                CMD_VERT: begin
                    kind_next  = SEG_LINE;
                    pen_y_next = sum_ay;
                end
                CMD_CUBIC: begin
                    kind_next     = SEG_CUBIC;
                    first_x_next  = sum_ax;
                    first_y_next  = sum_by;
                    second_x_next = sum_cx;
                    second_y_next = sum_dy;
                    ctrl_x_next   = sum_cx;
                    ctrl_y_next   = sum_dy;
                    pen_x_next    = sum_ex;
                    pen_y_next    = sum_fy;
                end
                CMD_SCUBIC: begin
                    kind_next     = SEG_CUBIC;
                    first_x_next  = refl_x;
                    first_y_next  = refl_y;
                    second_x_next = sum_ax;
                    second_y_next = sum_by;
                    ctrl_x_next   = sum_ax;
                    ctrl_y_next   = sum_by;
                    pen_x_next    = sum_cx;
                    pen_y_next    = sum_dy;
                end
                CMD_QUAD: begin
                    kind_next    = SEG_QUAD;
                    first_x_next = sum_ax;
                    first_y_next = sum_by;
                    ctrl_x_next  = sum_ax;
                    ctrl_y_next  = sum_by;
                    pen_x_next   = sum_cx;
                    pen_y_next   = sum_dy;
                end
                CMD_SQUAD: begin
                    kind_next    = SEG_QUAD;
                    first_x_next = refl_x;
                    first_y_next = refl_y;
                    ctrl_x_next  = refl_x;
                    ctrl_y_next  = refl_y;
                    pen_x_next   = sum_ax;
                    pen_y_next   = sum_by;
                end
                CMD_ARC: begin
                    kind_next     = SEG_ARC;
                    first_x_next  = q_item.a;
                    first_y_next  = q_item.b;
                    second_x_next = q_item.rad;
                    pen_x_next    = sum_ex;
                    pen_y_next    = sum_fy;
                    large_next    = q_item.lg;
                    sweep_next    = q_item.sw;
                end
                default: begin
                    kind_next  = SEG_CLOSE;
                    pen_x_next = start_x_reg;
                    pen_y_next = start_y_reg;
                end
            endcase
        end
        out_valid_next = q_pop || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            ctrl_x_reg    <= '0;
            ctrl_y_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                pen_x_reg   <= pen_x_next;
                pen_y_reg   <= pen_y_next;
                start_x_reg <= start_x_next;
                start_y_reg <= start_y_next;
                ctrl_x_reg  <= ctrl_x_next;
                ctrl_y_reg  <= ctrl_y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg     <= kind_next;
            first_x_reg  <= first_x_next;
            first_y_reg  <= first_y_next;
            second_x_reg <= second_x_next;
            second_y_reg <= second_y_next;
            end_x_reg    <= q_item.err ? '0 : pen_x_next;
            end_y_reg    <= q_item.err ? '0 : pen_y_next;
            large_reg    <= large_next;
            sweep_reg    <= sweep_next;
        end
    end

`ifndef SYNTHESIS
    a_error_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.err) |=> (pen_x_reg == $past(pen_x_reg))
                               && (start_y_reg == $past(start_y_reg)))
        else $error("error request changed the pen state");
    a_error_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && kind_reg == SEG_ERROR) |-> (end_x_reg == '0 && first_x_reg == '0))
        else $error("error segment carries coordinates");
`endif
endmodule
`default_nettype wire

[rtl/vector_path_command_interpreter_top.sv]
// Top level of the vector path command interpreter: front part, queue and back part.
//
//   Channel   Direction  tdata (low bit up)                         tuser
//   s_        in         arg_a..arg_f, large_arc, sweep_dir, pad     command, relative
//   m_        out        first_x..end_y, arc_large, arc_sweep, pad   segment_kind
//
// One request is accepted per cycle while s_tready is high; each segment passes through
// the front stage with the rotation multiply, the queue and the output register.
// Throughput is one segment per cycle while m_tready is high, with the pen updated per segment in the back part.
// Synchronous active-low reset clears the pen, subpath start, control point and error state.
// A stalled output fills the four-entry queue and then the front stage; only then is s_tready dropped.
`default_nettype none
module vector_path_command_interpreter_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // command[3:0], relative[4]
    input  wire logic [vpci_pkg::IN_TUSER_W-1:0]  s_tuser,
    // arg_a[31:0] .. arg_f[191:160], large_arc[192], sweep_dir[193], zero pad
    input  wire logic [vpci_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // segment_kind[2:0]
    output logic [vpci_pkg::OUT_TUSER_W-1:0]      m_tuser,
    // first_x[31:0], first_y, second_x, second_y, end_x, end_y[191:160],
    // arc_large[192], arc_sweep[193], zero pad
    output logic [vpci_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import vpci_pkg::*;

    logic        q_push, q_full, q_pop, q_not_empty;
    queue_item_t q_in_item, q_out_item;

    vpci_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_item   (q_in_item),
        .q_full   (q_full)
    );

    vpci_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .not_empty (q_not_empty)
    );

    vpci_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_item   (q_out_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire
